>>> rtl/core/rbd_pkg.sv
// Package for the ring buffer deque: command codes and controller states.
// No dependencies; imported by the controller and the top level.
`default_nettype none

package rbd_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_POP_FRONT  = 3'd1,
		CMD_PUSH_BACK  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_DRAIN      = 3'd4
	} cmd_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CMD_W  = 3;

endpackage

`default_nettype wire

>>> rtl/core/rbd_in_if.sv
// Command channel of the ring buffer deque: valid/ready with cmd and value.
// No dependencies.
`default_nettype none

interface rbd_in_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  cmd;
	logic signed [31:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rbd_out_if.sv
// Result channel of the ring buffer deque: valid/ready with drained entry and flags.
// No dependencies.
`default_nettype none

interface rbd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value_res;
	logic               last;
	logic               was_empty;

	modport source (output valid, output value_res, output last, output was_empty,
		input ready);
	modport sink   (input valid, input value_res, input last, input was_empty,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/rbd_mem.sv
// Entry store of the deque: one write port, one read port with registered data.
// The read register holds when rd_en is low and serves as the output register.
`default_nettype none

module rbd_mem #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [$clog2(DEPTH)-1:0]     waddr,
	input  wire logic signed [31:0]           wdata,
	input  wire logic                         rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]     raddr,
	output logic signed [31:0]                rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rbd_ctrl.sv
// Deque controller: head/tail/occupancy, push/pop writes, drain read sequencer.
// Depends on rbd_pkg; drives the write and read ports of rbd_mem.
`default_nettype none

module rbd_ctrl
	import rbd_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [CMD_W-1:0]     in_cmd,
	input  wire logic signed [31:0]   in_value,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      out_last,
	output logic                      out_empty,
	output logic                      we,
	output logic [AW-1:0]             waddr,
	output logic signed [31:0]        wdata,
	output logic                      rd_en,
	output logic [AW-1:0]             raddr
);

	state_t          state_q, state_d;
	logic [AW-1:0]   head_q, tail_q, rd_ptr_q;
	logic [CW-1:0]   occ_q, rem_q;
	logic            out_valid_s2, out_last_s2, out_empty_s2;
	logic            accept, advance, issue, is_full, is_empty;
	cmd_t            cmd;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
	endfunction

	assign cmd      = cmd_t'(in_cmd);
	assign accept   = in_valid && in_ready;
	assign is_full  = (occ_q == CW'(DEPTH));
	assign is_empty = (occ_q == '0);
	// read register may be refilled when it is empty or its transfer completes
	assign advance  = !out_valid_s2 || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_DRAIN) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (advance && rem_q <= CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		we       = 1'b0;
		waddr    = tail_q;
		unique case (state_q)
			ST_IDLE: begin
				// ready is high throughout idle, so valid alone marks a transfer
				in_ready = 1'b1;
				if (in_valid && !is_full) begin
					if (cmd == CMD_PUSH_FRONT) begin
						we    = 1'b1;
						waddr = ptr_dec(head_q);
					end else if (cmd == CMD_PUSH_BACK) begin
						we    = 1'b1;
						waddr = tail_q;
					end
				end
			end
			ST_DRAIN: begin
				issue = advance;
			end
			default: ;
		endcase
	end

	assign wdata = in_value;
	assign rd_en = issue;
	assign raddr = rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (cmd)
					CMD_PUSH_FRONT: begin
						if (!is_full) begin
							head_q <= ptr_dec(head_q);
							occ_q  <= occ_q + 1'b1;
						end
					end
					CMD_PUSH_BACK: begin
						if (!is_full) begin
							tail_q <= ptr_inc(tail_q);
							occ_q  <= occ_q + 1'b1;
						end
					end
					CMD_POP_FRONT: begin
						if (!is_empty) begin
							head_q <= ptr_inc(head_q);
							occ_q  <= occ_q - 1'b1;
						end
					end
					CMD_POP_BACK: begin
						if (!is_empty) begin
							tail_q <= ptr_dec(tail_q);
							occ_q  <= occ_q - 1'b1;
						end
					end
					CMD_DRAIN: begin
						// pointers clear at once; the sequencer walks its own copy
						head_q <= '0;
						tail_q <= '0;
						occ_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_DRAIN) begin
			rd_ptr_q <= head_q;
			rem_q    <= occ_q;
		end else if (issue) begin
			rd_ptr_q <= ptr_inc(rd_ptr_q);
			rem_q    <= (rem_q == '0) ? '0 : rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (issue) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			out_last_s2  <= (rem_q <= CW'(1));
			out_empty_s2 <= (rem_q == '0);
		end
	end

	assign out_valid = out_valid_s2;
	assign out_last  = out_last_s2;
	assign out_empty = out_empty_s2;

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		is_empty |-> head_q == tail_q)
		else $error("empty deque with head and tail apart");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == ST_IDLE && accept)
		else $error("memory write outside an accepted push");

	a_empty_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && rem_q == '0) |=> out_valid_s2 && out_last_s2 && out_empty_s2)
		else $error("empty drain did not give a single flagged result");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_DRAIN) |=> occ_q == '0 && state_q == ST_DRAIN)
		else $error("drain did not clear the deque");

endmodule

`default_nettype wire

>>> rtl/core/ring_buffer_deque.sv
// Channel   Dir  Payload                          Transfer
// in_ch     in   cmd[2:0], value[31:0] signed      valid && ready
// out_ch    out  value_res[31:0], last, was_empty  valid && ready
//
// Push and pop commands need no memory read; the input is ready every cycle
// while no drain runs, also while a drained result still waits on out_ch.
// A drain of N entries issues max(N,1) memory reads through the single read port,
// each while the read register may be refilled; the input stalls meanwhile.
// Output stalls hold the memory read register; no entry is reread.
// Reset (arst_n low) empties the deque at once; the store itself is not cleared.
`default_nettype none

module ring_buffer_deque
	import rbd_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rbd_in_if.sink      in_ch,
	rbd_out_if.source   out_ch
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic                we, rd_en, out_empty;
	logic [AW-1:0]       waddr, raddr;
	logic signed [31:0]  wdata, rdata;

	rbd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_cmd    (in_ch.cmd),
		.in_value  (in_ch.value),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_last  (out_ch.last),
		.out_empty (out_empty),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.rd_en     (rd_en),
		.raddr     (raddr)
	);

	rbd_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.rd_en (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// an empty drain reads a stale slot; its value is forced to zero
	assign out_ch.value_res = out_empty ? '0 : rdata;
	assign out_ch.was_empty = out_empty;

endmodule

`default_nettype wire
